// ----- rtl/vpd_pkg.sv -----
// Shared types and constants for the vibration pattern driver.
package vpd_pkg;

    // Slot drive modes
    typedef enum logic [1:0] {
        MODE_OFF     = 2'd0,
        MODE_REPEAT  = 2'd1,
        MODE_RATE    = 2'd2,
        MODE_ONESHOT = 2'd3
    } mode_t;

    // Sequencer states
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_LOAD,
        ST_RUN,
        ST_FLUSH
    } vpd_state_t;

    // Input item kinds (tuser)
    localparam logic ACTION_TICK = 1'b0;
    localparam logic ACTION_LOAD = 1'b1;

    // Motor commands
    localparam logic CMD_STOP  = 1'b0;
    localparam logic CMD_START = 1'b1;

    // Configuration register indexes
    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] CFG_PRESENT = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ENABLE  = 2'd1;

    // Field widths fixed by the interface
    localparam int SLOT_W  = 2;
    localparam int MASK_W  = 16;
    localparam int ACC_W   = 12;
    localparam int STEP_W  = 11;
    localparam int DRIVE_W = 3;
    localparam int CFG_W   = 4;

    // Pattern and phase constants
    localparam logic [MASK_W-1:0] PATTERN_START = 16'h8000;
    localparam logic [ACC_W-1:0]  PHASE_WRAP    = 12'h400;

    // Drive counter codes: 1 driving, 0 idle, negative = stops left to retry
    localparam logic signed [DRIVE_W-1:0] DRIVE_IDLE  = 3'sd0;
    localparam logic signed [DRIVE_W-1:0] DRIVE_ON    = 3'sd1;
    localparam logic signed [DRIVE_W-1:0] DRIVE_RETRY = -3'sd2;
    localparam logic signed [DRIVE_W-1:0] DRIVE_INC   = 3'sd1;

    // One slot's stored state
    typedef struct packed {
        mode_t                      mode;
        logic [MASK_W-1:0]          mask;
        logic [MASK_W-1:0]          pbit;
        logic [ACC_W-1:0]           acc;
        logic [STEP_W-1:0]          step;
        logic signed [DRIVE_W-1:0]  drive;
    } slot_state_t;

    // Outcome of one slot update
    typedef struct packed {
        logic wr_en;
        logic emit;
        logic cmd;
    } upd_result_t;

endpackage

// ----- rtl/vpd_slot_mem.sv -----
// Slot state memory: one write port, one registered read port, per-entry valid bits.
module vpd_slot_mem
    import vpd_pkg::*;
#(
    parameter int DEPTH  = 4,
    parameter int ADDR_W = 2
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              rd_en,
    input  logic [ADDR_W-1:0] rd_addr,
    output slot_state_t       rd_data,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  slot_state_t       wr_data
);

    slot_state_t        mem [DEPTH];
    logic [DEPTH-1:0]   valid_reg;
    slot_state_t        rd_data_reg;
    logic               rd_valid_reg;

    // Write entry
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Mark written entries valid; reset clears all
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else if (wr_en) begin
            valid_reg[wr_addr] <= 1'b1;
        end
    end

    // Registered read
    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data_reg  <= mem[rd_addr];
            rd_valid_reg <= valid_reg[rd_addr];
        end
    end

    // Unwritten entries read as the reset state
    assign rd_data = rd_valid_reg ? rd_data_reg : slot_state_t'('0);

endmodule

// ----- rtl/vpd_slot_update.sv -----
// Per-slot tick update: pattern/phase request and start/stop command decision.
module vpd_slot_update
    import vpd_pkg::*;
(
    input  slot_state_t entry_in,
    input  logic        present,
    input  logic        enabled,
    input  logic        halt,
    output slot_state_t entry_out,
    output upd_result_t result
);

    logic              req;
    logic [MASK_W-1:0] shifted;
    logic [ACC_W-1:0]  acc_sum;

    always_comb begin
        entry_out  = entry_in;
        result     = '0;
        req        = 1'b0;
        shifted    = entry_in.pbit >> 1;
        acc_sum    = entry_in.acc + ACC_W'(entry_in.step);

        if (present) begin
            result.wr_en = 1'b1;
            if (halt || !enabled) begin
                // Forced stop: drop to off, retry outstanding stops
                entry_out.mode = MODE_OFF;
                if (entry_in.drive != DRIVE_IDLE) begin
                    result.emit = 1'b1;
                    result.cmd  = CMD_STOP;
                    entry_out.drive = (entry_in.drive > DRIVE_IDLE) ? DRIVE_RETRY
                                                                    : entry_in.drive + DRIVE_INC;
                end
            end else begin
                // Work out the drive request from the mode
                case (entry_in.mode)
                    MODE_REPEAT, MODE_ONESHOT: begin
                        req = |(entry_in.pbit & entry_in.mask);
                        entry_out.pbit = shifted;
                        if (shifted == '0) begin
                            if (entry_in.mode == MODE_REPEAT) begin
                                entry_out.pbit = PATTERN_START;
                            end else begin
                                entry_out.mode = MODE_OFF;
                            end
                        end
                    end
                    MODE_RATE: begin
                        entry_out.acc = acc_sum;
                        if (acc_sum > PHASE_WRAP) begin
                            entry_out.acc = acc_sum - PHASE_WRAP;
                            req = 1'b1;
                        end
                    end
                    default: begin
                        req = 1'b0;
                    end
                endcase

                // Start on a rising request, otherwise wind down stops
                if (req) begin
                    if (entry_in.drive <= DRIVE_IDLE) begin
                        result.emit     = 1'b1;
                        result.cmd      = CMD_START;
                        entry_out.drive = DRIVE_ON;
                    end
                end else if (entry_in.drive != DRIVE_IDLE) begin
                    result.emit = 1'b1;
                    result.cmd  = CMD_STOP;
                    entry_out.drive = (entry_in.drive > DRIVE_IDLE) ? DRIVE_RETRY
                                                                    : entry_in.drive + DRIVE_INC;
                end
            end
        end
    end

endmodule

// ----- rtl/vibration_pattern_driver.sv -----
// Vibration pattern driver: up to four motor slots driven by pattern or phase rate.
//
// Input channel (s_*): one request per item. tuser selects a tick or a slot load.
// A load writes one slot's mode, mask and phase step.
// A tick walks the slots in order through the slot memory, one slot per cycle
// while the receiver does not stall, with the read of the next slot overlapped,
// and emits one command per slot that starts or stops its motor; the last
// command of the tick carries tlast. When the output drains freely, the single
// read port of the slot memory sets the pace of a tick.
// Output channel (m_*): a registered result plus one pending stage; the pending
// stage holds each command until the next one or the end of the tick decides
// its tlast. When the receiver stalls, slot processing waits and the input
// channel stays not ready until the tick has finished.
// Configuration channel (cfg_*): always ready; index 0 present mask, index 1
// enable mask, other indexes ignored. Write only while the block is idle.
// Reset (aresetn low, synchronous) clears the configuration, the slot state
// valid bits (all slots read as off and idle) and all handshakes.
module vibration_pattern_driver
    import vpd_pkg::*;
#(
    parameter int NUM_SLOTS = 4
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    // Input channel
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [31:0]          s_tdata,   // slot[1:0], halt[2], mode[4:3],
                                            // pattern_mask[20:5], phase_step[31:21]
    input  logic                 s_tuser,   // action
    // Result channel
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [7:0]           m_tdata,   // out_slot[1:0], command[2], zero[7:3]
    output logic                 m_tlast,
    // Configuration channel
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]     cfg_data
);

    localparam int ACTIVE_SLOTS = (NUM_SLOTS < 4) ? NUM_SLOTS : 4;
    localparam int ADDR_W       = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
    localparam logic [SLOT_W-1:0] LAST_IDX   = SLOT_W'(ACTIVE_SLOTS - 1);
    localparam logic [3:0]        SLOT_LIMIT = 4'(NUM_SLOTS);

    // Input field slices
    logic [SLOT_W-1:0] in_slot;
    logic              in_halt;
    logic [1:0]        in_mode;
    logic [MASK_W-1:0] in_mask;
    logic [STEP_W-1:0] in_step;
    logic              in_load_ok;

    assign in_slot    = s_tdata[1:0];
    assign in_halt    = s_tdata[2];
    assign in_mode    = s_tdata[4:3];
    assign in_mask    = s_tdata[20:5];
    assign in_step    = s_tdata[31:21];
    assign in_load_ok = ({2'b00, in_slot} < SLOT_LIMIT);

    // Registers
    vpd_state_t        state_reg, state_next;
    logic [CFG_W-1:0]  present_reg, present_next;
    logic [CFG_W-1:0]  enable_reg, enable_next;
    logic [SLOT_W-1:0] rd_idx_reg, rd_idx_next;
    logic              rd_done_reg, rd_done_next;
    logic [SLOT_W-1:0] p_idx_reg, p_idx_next;
    logic              halt_reg, halt_next;
    logic [SLOT_W-1:0] ld_idx_reg, ld_idx_next;
    logic              ld_ok_reg, ld_ok_next;
    logic [1:0]        ld_mode_reg, ld_mode_next;
    logic [MASK_W-1:0] ld_mask_reg, ld_mask_next;
    logic [STEP_W-1:0] ld_step_reg, ld_step_next;
    logic              pend_valid_reg, pend_valid_next;
    logic [SLOT_W-1:0] pend_slot_reg, pend_slot_next;
    logic              pend_cmd_reg, pend_cmd_next;
    logic              m_tvalid_reg, m_tvalid_next;
    logic [SLOT_W-1:0] m_slot_reg, m_slot_next;
    logic              m_cmd_reg, m_cmd_next;
    logic              m_last_reg, m_last_next;

    // Control
    logic              out_free;
    logic              can_proc;
    logic              mem_rd_en;
    logic [SLOT_W-1:0] rd_sel;
    logic              proc_en;
    logic              flush_push;
    logic              mem_wr_en;
    logic [SLOT_W-1:0] wr_sel;
    slot_state_t       mem_wr_data;
    slot_state_t       mem_rd_data;
    slot_state_t       upd_entry;
    upd_result_t       upd_res;
    logic              tick_accept;
    logic              load_accept;

    assign out_free    = !m_tvalid_reg || m_tready;
    assign can_proc    = !pend_valid_reg || out_free;
    assign tick_accept = s_tvalid && s_tready && (s_tuser == ACTION_TICK);
    assign load_accept = s_tvalid && s_tready && (s_tuser == ACTION_LOAD);

    // Slot state memory
    vpd_slot_mem #(
        .DEPTH  (NUM_SLOTS),
        .ADDR_W (ADDR_W)
    ) u_mem (
        .aclk    (aclk),
        .aresetn (aresetn),
        .rd_en   (mem_rd_en),
        .rd_addr (ADDR_W'(rd_sel)),
        .rd_data (mem_rd_data),
        .wr_en   (mem_wr_en),
        .wr_addr (ADDR_W'(wr_sel)),
        .wr_data (mem_wr_data)
    );

    // Slot update logic
    vpd_slot_update u_upd (
        .entry_in  (mem_rd_data),
        .present   (present_reg[p_idx_reg]),
        .enabled   (enable_reg[p_idx_reg]),
        .halt      (halt_reg),
        .entry_out (upd_entry),
        .result    (upd_res)
    );

    // Next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (tick_accept) begin
                    state_next = ST_RUN;
                end else if (load_accept) begin
                    state_next = ST_LOAD;
                end
            end
            ST_LOAD: begin
                state_next = ST_IDLE;
            end
            ST_RUN: begin
                if (can_proc && rd_done_reg) begin
                    state_next = ST_FLUSH;
                end
            end
            ST_FLUSH: begin
                if (!pend_valid_reg || out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // State outputs
    always_comb begin
        s_tready   = 1'b0;
        mem_rd_en  = 1'b0;
        rd_sel     = rd_idx_reg;
        proc_en    = 1'b0;
        flush_push = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                s_tready  = 1'b1;
                mem_rd_en = s_tvalid && ((s_tuser == ACTION_TICK) || in_load_ok);
                rd_sel    = (s_tuser == ACTION_TICK) ? '0 : in_slot;
            end
            ST_LOAD: begin
                s_tready = 1'b0;
            end
            ST_RUN: begin
                proc_en   = can_proc;
                mem_rd_en = can_proc && !rd_done_reg;
            end
            ST_FLUSH: begin
                flush_push = pend_valid_reg && out_free;
            end
            default: begin
                s_tready = 1'b0;
            end
        endcase
    end

    // Memory write: load entry or write back the updated slot
    always_comb begin
        mem_wr_en   = 1'b0;
        wr_sel      = p_idx_reg;
        mem_wr_data = upd_entry;
        if (state_reg == ST_LOAD) begin
            mem_wr_en         = ld_ok_reg;
            wr_sel            = ld_idx_reg;
            mem_wr_data.mode  = mode_t'(ld_mode_reg);
            mem_wr_data.mask  = ld_mask_reg;
            mem_wr_data.pbit  = PATTERN_START;
            mem_wr_data.acc   = '0;
            mem_wr_data.step  = ld_step_reg;
            mem_wr_data.drive = mem_rd_data.drive;
        end else if (proc_en) begin
            mem_wr_en = upd_res.wr_en;
        end
    end

    // Datapath next values
    always_comb begin
        present_next    = present_reg;
        enable_next     = enable_reg;
        rd_idx_next     = rd_idx_reg;
        rd_done_next    = rd_done_reg;
        p_idx_next      = p_idx_reg;
        halt_next       = halt_reg;
        ld_idx_next     = ld_idx_reg;
        ld_ok_next      = ld_ok_reg;
        ld_mode_next    = ld_mode_reg;
        ld_mask_next    = ld_mask_reg;
        ld_step_next    = ld_step_reg;
        pend_valid_next = pend_valid_reg;
        pend_slot_next  = pend_slot_reg;
        pend_cmd_next   = pend_cmd_reg;
        m_tvalid_next   = m_tvalid_reg && !m_tready;
        m_slot_next     = m_slot_reg;
        m_cmd_next      = m_cmd_reg;
        m_last_next     = m_last_reg;

        // Configuration writes; unknown indexes drop
        if (cfg_valid) begin
            case (cfg_index)
                CFG_PRESENT: present_next = cfg_data;
                CFG_ENABLE:  enable_next  = cfg_data;
                default:     present_next = present_reg;
            endcase
        end

        // Start a tick at slot 0
        if (tick_accept) begin
            halt_next    = in_halt;
            p_idx_next   = '0;
            rd_idx_next  = SLOT_W'(1);
            rd_done_next = (LAST_IDX == '0);
        end

        // Capture load fields
        if (load_accept) begin
            ld_idx_next  = in_slot;
            ld_ok_next   = in_load_ok;
            ld_mode_next = in_mode;
            ld_mask_next = in_mask;
            ld_step_next = in_step;
        end

        // Advance the slot walk
        if (proc_en) begin
            if (!rd_done_reg) begin
                p_idx_next   = rd_idx_reg;
                rd_idx_next  = rd_idx_reg + SLOT_W'(1);
                rd_done_next = (rd_idx_reg == LAST_IDX);
            end
            if (upd_res.emit) begin
                if (pend_valid_reg) begin
                    m_tvalid_next = 1'b1;
                    m_slot_next   = pend_slot_reg;
                    m_cmd_next    = pend_cmd_reg;
                    m_last_next   = 1'b0;
                end
                pend_valid_next = 1'b1;
                pend_slot_next  = p_idx_reg;
                pend_cmd_next   = upd_res.cmd;
            end
        end

        // Close the tick: the held command is the last one
        if (flush_push) begin
            m_tvalid_next   = 1'b1;
            m_slot_next     = pend_slot_reg;
            m_cmd_next      = pend_cmd_reg;
            m_last_next     = 1'b1;
            pend_valid_next = 1'b0;
        end
    end

    // Control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            present_reg    <= '0;
            enable_reg     <= '0;
            rd_done_reg    <= 1'b0;
            pend_valid_reg <= 1'b0;
            m_tvalid_reg   <= 1'b0;
        end else begin
            state_reg      <= state_next;
            present_reg    <= present_next;
            enable_reg     <= enable_next;
            rd_done_reg    <= rd_done_next;
            pend_valid_reg <= pend_valid_next;
            m_tvalid_reg   <= m_tvalid_next;
        end
    end

    // Payload registers
    always_ff @(posedge aclk) begin
        rd_idx_reg    <= rd_idx_next;
        p_idx_reg     <= p_idx_next;
        halt_reg      <= halt_next;
        ld_idx_reg    <= ld_idx_next;
        ld_ok_reg     <= ld_ok_next;
        ld_mode_reg   <= ld_mode_next;
        ld_mask_reg   <= ld_mask_next;
        ld_step_reg   <= ld_step_next;
        pend_slot_reg <= pend_slot_next;
        pend_cmd_reg  <= pend_cmd_next;
        m_slot_reg    <= m_slot_next;
        m_cmd_reg     <= m_cmd_next;
        m_last_reg    <= m_last_next;
    end

    assign cfg_ready = 1'b1;
    assign m_tvalid  = m_tvalid_reg;
    assign m_tdata   = {5'b00000, m_cmd_reg, m_slot_reg};
    assign m_tlast   = m_last_reg;

    // No command stays held once the block is idle
    assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_IDLE) |-> !pend_valid_reg)
        else $error("pending command left over in idle");

    // A slot is never read and written back in the same cycle
    assert property (@(posedge aclk) disable iff (!aresetn)
        (mem_wr_en && mem_rd_en) |-> (wr_sel != rd_sel))
        else $error("slot memory read and write collide");

    // Closing a tick with a held command presents it marked last
    assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_FLUSH && pend_valid_reg && out_free) |=> (m_tvalid && m_tlast))
        else $error("tick closed without a last command");

endmodule

// ----- sim/vibration_pattern_driver_tb.sv -----
// Self-checking testbench for the vibration pattern driver: random and directed slot traffic.
module vibration_pattern_driver_tb;
    import vpd_pkg::*;

    localparam int NUM_SLOTS      = 4;
    localparam int PHASE_ITEMS    = 58;
    localparam int SETTLE_CYCLES  = 16;
    localparam int RX_HOLD_CYCLES = 100;
    localparam int STALL_LIMIT    = 2000;

    // Register indexes that the block ignores
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_A = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_B = 2'd3;

    // Drive counter value set when a request drops, before its first stop counts down
    localparam logic signed [DRIVE_W-1:0] DRIVE_FIRST_STOP = -3'sd3;

    // One input request as the sender sees it
    typedef struct packed {
        logic              action;
        logic [SLOT_W-1:0] slot;
        logic              halt;
        mode_t             mode;
        logic [MASK_W-1:0] pattern;
        logic [STEP_W-1:0] step;
    } vib_req_t;

    // One motor command
    typedef struct packed {
        logic [SLOT_W-1:0] slot;
        logic              cmd;
        logic              last;
    } vib_cmd_t;

    // Slot model and queue of expected motor commands
    class motor_cmd_scoreboard;
        logic [CFG_W-1:0]          present;
        logic [CFG_W-1:0]          enable;
        mode_t                     mode_q  [NUM_SLOTS];
        logic [MASK_W-1:0]         mask_q  [NUM_SLOTS];
        logic [MASK_W-1:0]         pbit_q  [NUM_SLOTS];
        logic [ACC_W-1:0]          acc_q   [NUM_SLOTS];
        logic [STEP_W-1:0]         step_q  [NUM_SLOTS];
        logic signed [DRIVE_W-1:0] drive_q [NUM_SLOTS];
        vib_cmd_t                  expected_cmds[$];
        int errors, n_loads, n_ticks, n_checked, n_starts, n_stops, n_writes;

        function new();
            present = '0;
            enable  = '0;
            for (int i = 0; i < NUM_SLOTS; i++) begin
                mode_q[i]  = MODE_OFF;
                mask_q[i]  = '0;
                pbit_q[i]  = '0;
                acc_q[i]   = '0;
                step_q[i]  = '0;
                drive_q[i] = DRIVE_IDLE;
            end
            errors = 0; n_loads = 0; n_ticks = 0; n_checked = 0;
            n_starts = 0; n_stops = 0; n_writes = 0;
        endfunction

        function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] val);
            n_writes++;
            if (idx == CFG_PRESENT)
                present = val;
            else if (idx == CFG_ENABLE)
                enable = val;
        endfunction

        // Advance the slot model by one accepted request
        function void note_request(vib_req_t r);
            vib_cmd_t          tick_cmds[$];
            vib_cmd_t          c;
            logic              want;
            logic              fire;
            logic              cmd;
            logic [MASK_W-1:0] b;
            logic [ACC_W-1:0]  a;
            if (r.action == ACTION_LOAD) begin
                n_loads++;
                if (int'(r.slot) < NUM_SLOTS) begin
                    mode_q[r.slot] = r.mode;
                    mask_q[r.slot] = r.pattern;
                    step_q[r.slot] = r.step;
                    pbit_q[r.slot] = PATTERN_START;
                    acc_q[r.slot]  = '0;
                end
                return;
            end
            n_ticks++;
            for (int i = 0; i < NUM_SLOTS && i < 4; i++) begin
                want = 1'b0;
                fire = 1'b0;
                cmd  = CMD_STOP;
                if (present[i]) begin
                    if (r.halt || !enable[i]) begin
                        // Forced stop: retry stops until the counter is idle
                        mode_q[i] = MODE_OFF;
                        if (drive_q[i] != DRIVE_IDLE) begin
                            fire = 1'b1;
                            drive_q[i] = (drive_q[i] > DRIVE_IDLE) ? DRIVE_RETRY
                                                                   : drive_q[i] + DRIVE_INC;
                        end
                    end else begin
                        case (mode_q[i])
                            MODE_REPEAT, MODE_ONESHOT: begin
                                b = pbit_q[i];
                                want = |(b & mask_q[i]);
                                b = b >> 1;
                                if (b == '0) begin
                                    if (mode_q[i] == MODE_REPEAT)
                                        b = PATTERN_START;
                                    else
                                        mode_q[i] = MODE_OFF;
                                end
                                pbit_q[i] = b;
                            end
                            MODE_RATE: begin
                                a = acc_q[i] + {1'b0, step_q[i]};
                                if (a > PHASE_WRAP) begin
                                    a = a - PHASE_WRAP;
                                    want = 1'b1;
                                end
                                acc_q[i] = a;
                            end
                            default: want = 1'b0;
                        endcase
                        if (want) begin
                            if (drive_q[i] <= DRIVE_IDLE) begin
                                fire = 1'b1;
                                cmd  = CMD_START;
                                drive_q[i] = DRIVE_ON;
                            end
                        end else begin
                            if (drive_q[i] > DRIVE_IDLE)
                                drive_q[i] = DRIVE_FIRST_STOP;
                            if (drive_q[i] < DRIVE_IDLE) begin
                                fire = 1'b1;
                                drive_q[i] = drive_q[i] + DRIVE_INC;
                            end
                        end
                    end
                    if (fire) begin
                        c.slot = SLOT_W'(i);
                        c.cmd  = cmd;
                        c.last = 1'b0;
                        tick_cmds.push_back(c);
                    end
                end
            end
            // Mark the final command of the tick
            for (int k = 0; k < tick_cmds.size(); k++) begin
                c = tick_cmds[k];
                c.last = (k == tick_cmds.size() - 1);
                expected_cmds.push_back(c);
            end
        endfunction

        // Compare one accepted command with the oldest expectation
        function void check_command(logic [7:0] data, logic last_flag);
            vib_cmd_t want;
            if (expected_cmds.size() == 0) begin
                errors++;
                $display("%0t: unexpected command: slot %0d cmd %0d last %0d",
                         $time, data[1:0], data[2], last_flag);
                return;
            end
            want = expected_cmds.pop_front();
            n_checked++;
            if (data[2] == CMD_START)
                n_starts++;
            else
                n_stops++;
            if (want.slot !== data[1:0]) begin
                errors++;
                $display("%0t: out_slot mismatch: expected %0d actual %0d",
                         $time, want.slot, data[1:0]);
            end
            if (want.cmd !== data[2]) begin
                errors++;
                $display("%0t: command mismatch (slot %0d): expected %0d actual %0d",
                         $time, want.slot, want.cmd, data[2]);
            end
            if (want.last !== last_flag) begin
                errors++;
                $display("%0t: last mismatch (slot %0d): expected %0d actual %0d",
                         $time, want.slot, want.last, last_flag);
            end
        endfunction
    endclass

    logic                 aclk;
    logic                 aresetn   = 1'b0;
    logic                 s_tvalid  = 1'b0;
    logic                 s_tready;
    logic [31:0]          s_tdata   = '0;  // slot[1:0], halt[2], mode[4:3],
                                           // pattern_mask[20:5], phase_step[31:21]
    logic                 s_tuser   = 1'b0; // action
    logic                 m_tvalid;
    logic                 m_tready  = 1'b0;
    logic [7:0]           m_tdata;          // out_slot[1:0], command[2], zero[7:3]
    logic                 m_tlast;
    logic                 cfg_valid = 1'b0;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [CFG_W-1:0]     cfg_data  = '0;

    motor_cmd_scoreboard sb;
    vib_req_t            send_q[$];
    vib_req_t            tx_cur;
    vib_req_t            tx_next;
    int                  send_idle_pct = 0;
    int                  recv_idle_pct = 0;
    int                  rx_hold_token = 0;
    int                  rx_hold_seen  = 0;
    int                  rx_hold_left  = 0;
    int                  stall_cycles  = 0;

    vibration_pattern_driver #(.NUM_SLOTS(NUM_SLOTS)) u_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial begin
        aclk = 1'b0;
        forever #2 aclk = ~aclk;
    end

    // Offer queued requests, with random gaps
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else begin
            if (s_tvalid && s_tready)
                sb.note_request(tx_cur);
            if (!s_tvalid || s_tready) begin
                if (send_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                    tx_next = send_q.pop_front();
                    tx_cur   <= tx_next;
                    s_tvalid <= 1'b1;
                    s_tdata  <= {tx_next.step, tx_next.pattern, tx_next.mode,
                                 tx_next.halt, tx_next.slot};
                    s_tuser  <= tx_next.action;
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // Accept commands, stalling at random or for a long hold-off on request
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            if (m_tvalid && m_tready)
                sb.check_command(m_tdata, m_tlast);
            if (rx_hold_seen != rx_hold_token) begin
                rx_hold_seen <= rx_hold_token;
                rx_hold_left <= RX_HOLD_CYCLES;
                m_tready     <= 1'b0;
            end else if (rx_hold_left > 0) begin
                rx_hold_left <= rx_hold_left - 1;
                m_tready     <= 1'b0;
            end else begin
                m_tready <= ($urandom_range(99) >= recv_idle_pct);
            end
        end
    end

    // Abort when no channel moves for too long
    always @(posedge aclk) begin
        if (aresetn) begin
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
                stall_cycles <= 0;
            else
                stall_cycles <= stall_cycles + 1;
            if (stall_cycles >= STALL_LIMIT) begin
                $display("%0t: no progress for %0d cycles, %0d commands still expected",
                         $time, STALL_LIMIT, sb.expected_cmds.size());
                $display("[vibration_pattern_driver] ERROR");
                $finish;
            end
        end
    end

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] val);
        @(posedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        sb.write_reg(idx, val);
    endtask

    task automatic set_masks(logic [CFG_W-1:0] present, logic [CFG_W-1:0] enable);
        write_reg(CFG_PRESENT, present);
        write_reg(CFG_ENABLE, enable);
    endtask

    // Hold until every request is taken and every command has come back
    task automatic wait_drained();
        do @(negedge aclk);
        while (send_q.size() != 0 || s_tvalid || sb.expected_cmds.size() != 0);
        repeat (SETTLE_CYCLES) @(negedge aclk);
    endtask

    task automatic queue_load(logic [SLOT_W-1:0] slot, mode_t mode, logic [MASK_W-1:0] pattern,
                              logic [STEP_W-1:0] step, logic halt);
        vib_req_t r;
        r.action  = ACTION_LOAD;
        r.slot    = slot;
        r.halt    = halt;
        r.mode    = mode;
        r.pattern = pattern;
        r.step    = step;
        send_q.push_back(r);
    endtask

    // Tick with random content in the fields a tick ignores
    task automatic queue_tick(logic halt);
        vib_req_t r;
        r.action  = ACTION_TICK;
        r.slot    = SLOT_W'($urandom_range(3));
        r.halt    = halt;
        r.mode    = mode_t'($urandom_range(3));
        r.pattern = MASK_W'($urandom);
        r.step    = STEP_W'($urandom_range(2047));
        send_q.push_back(r);
    endtask

    function automatic logic [MASK_W-1:0] random_mask();
        int pick;
        pick = $urandom_range(99);
        if (pick < 10)
            return '0;
        if (pick < 20)
            return '1;
        if (pick < 35)
            return MASK_W'(1) << $urandom_range(15);
        if (pick < 50) begin
            case ($urandom_range(3))
                0: return 16'hAAAA;
                1: return 16'h5555;
                2: return 16'hF0F0;
                default: return 16'h00FF;
            endcase
        end
        return MASK_W'($urandom);
    endfunction

    function automatic logic [STEP_W-1:0] random_step();
        int pick;
        pick = $urandom_range(99);
        if (pick < 8)
            return STEP_W'(1024);
        if (pick < 16)
            return STEP_W'($urandom_range(2047, 1025));
        if (pick < 24)
            return '0;
        return STEP_W'($urandom_range(1023));
    endfunction

    // Mostly ticks, with loads spread thin so patterns run long enough to wrap
    task automatic queue_random();
        if ($urandom_range(99) < 18)
            queue_load(SLOT_W'($urandom_range(3)), mode_t'($urandom_range(3)),
                       random_mask(), random_step(), 1'($urandom_range(1)));
        else
            queue_tick(1'($urandom_range(99) < 7));
    endtask

    initial begin
        sb = new();
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;

        // Directed: every mode, mask and step extremes, halt and retries
        set_masks(4'hF, 4'hF);
        queue_tick(1'b0);
        queue_load(2'd0, MODE_REPEAT, 16'hFFFF, 11'd0, 1'b0);
        queue_load(2'd1, MODE_RATE, 16'h0000, 11'd1024, 1'b0);
        queue_load(2'd2, MODE_ONESHOT, 16'h8001, 11'd0, 1'b0);
        queue_load(2'd3, MODE_RATE, 16'h1234, 11'd2047, 1'b0);
        repeat (6) queue_tick(1'b0);
        queue_tick(1'b1);
        repeat (3) queue_tick(1'b0);
        queue_load(2'd0, MODE_OFF, 16'hFFFF, 11'd1024, 1'b0);
        queue_load(2'd1, MODE_REPEAT, 16'h0001, 11'd5, 1'b1);
        queue_load(2'd2, MODE_RATE, 16'hFFFF, 11'd0, 1'b0);
        queue_load(2'd3, MODE_ONESHOT, 16'h0000, 11'd1024, 1'b0);
        repeat (3) queue_tick(1'b0);
        wait_drained();

        // Partial present and enable masks; spare indexes must be ignored
        set_masks(4'b1011, 4'b0110);
        write_reg(CFG_SPARE_A, 4'hF);
        write_reg(CFG_SPARE_B, 4'h0);
        repeat (3) queue_tick(1'b0);
        wait_drained();

        // Random traffic under each idling mix
        for (int phase = 0; phase < 4; phase++) begin
            case (phase)
                0: begin send_idle_pct = 0;  recv_idle_pct = 0;  set_masks(4'hF, 4'hF); end
                1: begin
                    send_idle_pct = 69; recv_idle_pct = 0;
                    set_masks(4'hF, CFG_W'($urandom_range(15)));
                end
                2: begin
                    send_idle_pct = 0; recv_idle_pct = 69;
                    set_masks(CFG_W'($urandom_range(15)), 4'hF);
                end
                default: begin
                    send_idle_pct = 24; recv_idle_pct = 24;
                    set_masks(CFG_W'($urandom_range(15, 1)), CFG_W'($urandom_range(15)));
                end
            endcase
            repeat (PHASE_ITEMS) queue_random();
            wait_drained();
        end

        // All slots disabled, then no slot present
        send_idle_pct = 24; recv_idle_pct = 24;
        set_masks(4'hF, 4'h0);
        repeat (8) queue_random();
        wait_drained();
        set_masks(4'h0, 4'hF);
        repeat (6) queue_random();
        wait_drained();

        // Long receiver hold-off while every slot toggles each tick
        send_idle_pct = 0; recv_idle_pct = 0;
        set_masks(4'hF, 4'hF);
        queue_load(2'd0, MODE_REPEAT, 16'hAAAA, 11'd0, 1'b0);
        queue_load(2'd1, MODE_REPEAT, 16'h5555, 11'd0, 1'b0);
        queue_load(2'd2, MODE_REPEAT, 16'hAAAA, 11'd0, 1'b0);
        queue_load(2'd3, MODE_REPEAT, 16'h5555, 11'd0, 1'b0);
        @(negedge aclk);
        rx_hold_token = rx_hold_token + 1;
        repeat (30) queue_tick(1'b0);
        wait_drained();

        // Short bursts, each drained before the next
        send_idle_pct = 24; recv_idle_pct = 24;
        repeat (3) begin
            repeat (8) queue_random();
            wait_drained();
        end

        if (sb.expected_cmds.size() != 0) begin
            sb.errors++;
            $display("%0t: %0d expected commands never arrived", $time,
                     sb.expected_cmds.size());
        end
        $display("Covered %0d loads and %0d ticks across %0d register writes.",
                 sb.n_loads, sb.n_ticks, sb.n_writes);
        $display("Checked %0d motor commands (%0d starts, %0d stops), %0d mismatches.",
                 sb.n_checked, sb.n_starts, sb.n_stops, sb.errors);
        if (sb.errors == 0)
            $display("[vibration_pattern_driver] OK");
        else
            $display("[vibration_pattern_driver] ERROR");
        $finish;
    end

endmodule
